// ----- hdl/mab_pkg.sv -----
// ----------------------------------------------------------------------------
// mab_pkg
// Shared sizes, operation and result codes, slot table interface types and
// the two-region sample mixing function of the audio block mixer.
// ----------------------------------------------------------------------------
package mab_pkg;

	localparam int CHANNELS      = 4;
	localparam int FRAME_SAMPLES = 512;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CS_W  = $clog2(CHANNELS + 1);
	localparam int POS_W = $clog2(FRAME_SAMPLES);

	localparam logic [7:0] SILENCE_LEVEL = 8'h7f;

	typedef enum logic [1:0] {
		OP_PLAY   = 2'd0,
		OP_STOP   = 2'd1,
		OP_FRAME  = 2'd2,
		OP_SAMPLE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_REQUEST = 2'd1,
		KIND_SILENCE = 2'd2,
		KIND_DONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic            play;
		logic            stop;
		logic            scan;
		logic [15:0]     id;
		logic [31:0]     blk;
		logic [31:0]     cnt;
		logic [CS_W-1:0] from;
	} slot_cmd_t;

	typedef struct packed {
		logic            found;
		logic [CH_W-1:0] slot;
		logic [31:0]     block;
	} slot_hit_t;

	function automatic logic [7:0] mix_samples(input logic [7:0] a, input logic [7:0] b);
		logic [15:0]        prod;
		logic [8:0]         p;
		logic signed [11:0] w;
		prod = {8'd0, a} * {8'd0, b};
		p    = prod[15:7];
		if (!a[7] && !b[7]) begin
			w = $signed({3'd0, p});
		end else begin
			w = $signed({3'd0, a, 1'b0}) + $signed({3'd0, b, 1'b0})
			    - $signed({3'd0, p}) - 12'sd256;
		end
		if (w < 12'sd0) begin
			return 8'd0;
		end else if (w > 12'sd255) begin
			return 8'd255;
		end else begin
			return w[7:0];
		end
	endfunction

endpackage

// ----- hdl/mab_slot_table.sv -----
// ----------------------------------------------------------------------------
// mab_slot_table
// Playback slot table: id, next block and blocks left per slot. Fills the
// first free slot on play, clears matching slots on stop, finds the next
// active slot from a given index and consumes one of its blocks.
// ----------------------------------------------------------------------------
module mab_slot_table (
	input  logic               clk,
	input  logic               arst_n,
	input  mab_pkg::slot_cmd_t cmd,
	output mab_pkg::slot_hit_t hit
);
	import mab_pkg::*;

	logic [15:0]     id_q   [CHANNELS];
	logic [31:0]     next_q [CHANNELS];
	logic [31:0]     rem_q  [CHANNELS];
	logic            free_found;
	logic [CH_W-1:0] free_slot;

	always_comb begin
		hit        = '0;
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = CHANNELS - 1; i >= 0; i--) begin
			if (rem_q[i] != 32'd0 && CS_W'(i) >= cmd.from) begin
				hit.found = 1'b1;
				hit.slot  = CH_W'(i);
				hit.block = next_q[i];
			end
			if (rem_q[i] == 32'd0) begin
				free_found = 1'b1;
				free_slot  = CH_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				id_q[i]   <= '0;
				next_q[i] <= '0;
				rem_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < CHANNELS; i++) begin
				if (cmd.play && free_found && free_slot == CH_W'(i)) begin
					id_q[i]   <= cmd.id;
					next_q[i] <= cmd.blk;
					rem_q[i]  <= cmd.cnt;
				end
				if (cmd.stop && id_q[i] == cmd.id) begin
					id_q[i]   <= '0;
					next_q[i] <= '0;
					rem_q[i]  <= '0;
				end
				if (cmd.scan && hit.found && hit.slot == CH_W'(i)) begin
					next_q[i] <= next_q[i] + 32'd1;
					rem_q[i]  <= rem_q[i] - 32'd1;
				end
			end
		end
	end

endmodule

// ----- hdl/multichannel_audio_block_mixer.sv -----
// ----------------------------------------------------------------------------
// multichannel_audio_block_mixer
// A result is registered in stage s1 and then in the output register; the end
// of a block adds a second result in the cycle after the first. One request per
// cycle, except that busy holds off a new request while the last sample of a
// block makes its second result. Reset empties the slot table and ends any
// frame; the frame store is not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module multichannel_audio_block_mixer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [15:0] sound_id,
	input  logic [31:0] start_block,
	input  logic [31:0] block_count,
	input  logic        card_ready,
	input  logic        buffer_half,
	input  logic [7:0]  sample,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [7:0]  mixed_sample,
	output logic [8:0]  sample_index,
	output logic        out_half,
	output logic [31:0] read_block,
	output logic [1:0]  channel,
	output logic        last
);
	import mab_pkg::*;

	logic [7:0]      frame_mem [FRAME_SAMPLES];

	op_t             op;
	logic            accept;
	logic            fs_go;
	logic            smp_go;
	logic            eob;
	slot_cmd_t       cmd;
	slot_hit_t       hit;

	logic            frame_busy_q;
	logic            mix_q;
	logic [CS_W-1:0] cur_q;
	logic [POS_W-1:0] pos_q;
	logic            half_q;

	logic            valid_s1;
	logic            two_s1;
	kind_t           kind_s1;
	logic [POS_W-1:0] pos_s1;
	logic [7:0]      smp_s1;
	logic            mix_s1;
	logic            half_s1;
	logic [31:0]     block_s1;
	logic [CH_W-1:0] chan_s1;
	logic [7:0]      frame_rd_s1;
	logic [7:0]      wval;

	logic            tail_q;
	kind_t           tkind_q;
	logic [31:0]     tblock_q;
	logic [CH_W-1:0] tchan_q;

	logic            strobe_q;
	kind_t           kind_q;
	logic [7:0]      mixed_q;
	logic [8:0]      index_q;
	logic            half_out_q;
	logic [31:0]     block_q;
	logic [1:0]      chan_q;
	logic            last_q;

	assign busy   = valid_s1 & two_s1;
	assign accept = start & ~busy;
	assign op     = op_t'(operation);
	assign eob    = (pos_q == POS_W'(FRAME_SAMPLES - 1));
	assign fs_go  = accept && op == OP_FRAME && card_ready && !frame_busy_q;
	assign smp_go = accept && op == OP_SAMPLE && frame_busy_q;

	always_comb begin
		cmd      = '0;
		cmd.id   = sound_id;
		cmd.blk  = start_block;
		cmd.cnt  = block_count;
		cmd.from = '0;
		unique case (op)
			OP_PLAY:   cmd.play = accept;
			OP_STOP:   cmd.stop = accept;
			OP_FRAME:  cmd.scan = fs_go;
			OP_SAMPLE: begin
				cmd.from = cur_q + CS_W'(1);
				cmd.scan = smp_go && eob;
			end
			default:   ;
		endcase
	end

	mab_slot_table u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.hit    (hit)
	);

	// control state, updated in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_busy_q <= 1'b0;
			mix_q        <= 1'b0;
			cur_q        <= '0;
			pos_q        <= '0;
			half_q       <= 1'b0;
			valid_s1     <= 1'b0;
			two_s1       <= 1'b0;
			tail_q       <= 1'b0;
			strobe_q     <= 1'b0;
		end else begin
			valid_s1 <= fs_go || smp_go;
			two_s1   <= smp_go && eob;
			tail_q   <= valid_s1 && two_s1;
			strobe_q <= valid_s1 || tail_q;
			if (fs_go) begin
				mix_q  <= 1'b0;
				half_q <= buffer_half;
				pos_q  <= '0;
				frame_busy_q <= hit.found;
				cur_q  <= hit.found ? CS_W'(hit.slot) : CS_W'(CHANNELS);
			end
			if (smp_go) begin
				if (eob) begin
					pos_q <= '0;
					mix_q <= 1'b1;
					frame_busy_q <= hit.found;
					cur_q <= hit.found ? CS_W'(hit.slot) : CS_W'(CHANNELS);
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		frame_rd_s1 <= frame_mem[pos_q];
		if (fs_go || smp_go) begin
			kind_s1  <= smp_go ? KIND_SAMPLE : (hit.found ? KIND_REQUEST : KIND_SILENCE);
			pos_s1   <= pos_q;
			smp_s1   <= sample;
			mix_s1   <= mix_q;
			half_s1  <= fs_go ? buffer_half : half_q;
			block_s1 <= hit.block;
			chan_s1  <= hit.slot;
		end
		if (smp_go && eob) begin
			tkind_q  <= hit.found ? KIND_REQUEST : KIND_DONE;
			tblock_q <= hit.block;
			tchan_q  <= hit.slot;
		end
	end

	assign wval = mix_s1 ? mix_samples(frame_rd_s1, smp_s1) : smp_s1;

	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == KIND_SAMPLE) begin
			frame_mem[pos_s1] <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_q) begin
			kind_q  <= tkind_q;
			mixed_q <= 8'd0;
			index_q <= 9'd0;
			block_q <= (tkind_q == KIND_REQUEST) ? tblock_q : 32'd0;
			chan_q  <= (tkind_q == KIND_REQUEST) ? 2'(tchan_q) : 2'd0;
			last_q  <= 1'b1;
		end else begin
			kind_q  <= kind_s1;
			mixed_q <= (kind_s1 == KIND_SAMPLE)  ? wval :
			           (kind_s1 == KIND_SILENCE) ? SILENCE_LEVEL : 8'd0;
			index_q <= (kind_s1 == KIND_SAMPLE) ? 9'(pos_s1) : 9'd0;
			block_q <= (kind_s1 == KIND_REQUEST) ? block_s1 : 32'd0;
			chan_q  <= (kind_s1 == KIND_REQUEST) ? 2'(chan_s1) : 2'd0;
			last_q  <= ~two_s1;
			half_out_q <= half_s1;
		end
	end

	assign strobe       = strobe_q;
	assign kind         = kind_q;
	assign mixed_sample = mixed_q;
	assign sample_index = index_q;
	assign out_half     = half_out_q;
	assign read_block   = block_q;
	assign channel      = chan_q;
	assign last         = last_q;

endmodule

// ----- hdl/mab_checker.sv -----
// ----------------------------------------------------------------------------
// mab_checker
// Port-level checks of the audio block mixer: busy length, result pairing,
// silence frame contents and play requests that give no result.
// ----------------------------------------------------------------------------
module mab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  operation,
	input logic        strobe,
	input logic [1:0]  kind,
	input logic [7:0]  mixed_sample,
	input logic [8:0]  sample_index,
	input logic        last
);
	import mab_pkg::*;

	a_busy_short: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && last)
		else $error("first of two results not followed by its second");

	a_silence: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_SILENCE |-> mixed_sample == SILENCE_LEVEL
			&& sample_index == 9'd0 && last)
		else $error("malformed silence frame result");

	a_play_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_PLAY |-> ##2 !strobe)
		else $error("play request produced a result");

endmodule

bind multichannel_audio_block_mixer mab_checker u_mab_checker (.*);
